[sv/b64e_pkg.sv]
// ---------------------------------------------------------------------------
// base64 encoder package
// shared types, constants and the sextet to character map
// ---------------------------------------------------------------------------
package b64e_pkg;

   localparam int BYTE_W        = 8;
   localparam int SEXTET_W      = 6;
   localparam int KEEP_W        = 3;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] PAD_CHAR    = 8'h3D;
   localparam logic [BYTE_W-1:0] UPPER_BASE  = 8'h41;
   localparam logic [BYTE_W-1:0] LOWER_BASE  = 8'h61;
   localparam logic [BYTE_W-1:0] DIGIT_BASE  = 8'h30;
   localparam logic [BYTE_W-1:0] PLUS_CHAR   = 8'h2B;
   localparam logic [BYTE_W-1:0] SLASH_CHAR  = 8'h2F;

   localparam logic [SEXTET_W-1:0] LOWER_START = 6'd26;
   localparam logic [SEXTET_W-1:0] DIGIT_START = 6'd52;
   localparam logic [SEXTET_W-1:0] PLUS_CODE   = 6'd62;
   localparam logic [SEXTET_W-1:0] SLASH_CODE  = 6'd63;

   localparam logic [KEEP_W-1:0] KEEP_ONE_BYTE  = 3'd2;
   localparam logic [KEEP_W-1:0] KEEP_TWO_BYTES = 3'd3;
   localparam logic [KEEP_W-1:0] KEEP_FULL      = 3'd4;

   // bytes[7:0] is the first byte of the group
   typedef struct packed {
      logic [3*BYTE_W-1:0] bytes;
      logic [KEEP_W-1:0]   keep;
      logic                last;
   } group_type;

   function automatic logic [BYTE_W-1:0] b64e_char(input logic [SEXTET_W-1:0] code);
      logic [BYTE_W-1:0] ext;
      ext = {2'b00, code};
      if (code < LOWER_START) begin
         return UPPER_BASE + ext;
      end else if (code < DIGIT_START) begin
         return LOWER_BASE + ext - {2'b00, LOWER_START};
      end else if (code < PLUS_CODE) begin
         return DIGIT_BASE + ext - {2'b00, DIGIT_START};
      end else if (code == PLUS_CODE) begin
         return PLUS_CHAR;
      end else begin
         return SLASH_CHAR;
      end
   endfunction

endpackage

[sv/b64e_front.sv]
// ---------------------------------------------------------------------------
// base64 encoder front
// collects message bytes into groups of three and queues finished groups
// ---------------------------------------------------------------------------
module b64e_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [b64e_pkg::BYTE_W-1:0]    data_byte,
   input  logic                           end_of_message,
   output logic                           push,
   output b64e_pkg::group_type            push_group
);
   import b64e_pkg::*;

   logic [1:0]        pos_ff, pos_in;
   logic [BYTE_W-1:0] pend0_ff, pend0_in;
   logic [BYTE_W-1:0] pend1_ff, pend1_in;
   logic              accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      pos_in     = pos_ff;
      pend0_in   = pend0_ff;
      pend1_in   = pend1_ff;
      push       = 1'b0;
      push_group = '0;
      if (accept) begin
         if (pos_ff == 2'd2) begin
            push             = 1'b1;
            push_group.bytes = {data_byte, pend1_ff, pend0_ff};
            push_group.keep  = KEEP_FULL;
            push_group.last  = end_of_message;
            pos_in           = 2'd0;
         end else if (end_of_message) begin
            push            = 1'b1;
            push_group.last = 1'b1;
            pos_in          = 2'd0;
            if (pos_ff == 2'd1) begin
               push_group.bytes = {{BYTE_W{1'b0}}, data_byte, pend0_ff};
               push_group.keep  = KEEP_TWO_BYTES;
            end else begin
               push_group.bytes = {{2*BYTE_W{1'b0}}, data_byte};
               push_group.keep  = KEEP_ONE_BYTE;
            end
         end else if (pos_ff == 2'd1) begin
            pend1_in = data_byte;
            pos_in   = 2'd2;
         end else begin
            pend0_in = data_byte;
            pos_in   = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3) else $error("group position out of range");
   a_push_on_end: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_message |-> push && push_group.last)
      else $error("message end not queued");
`endif

endmodule

[sv/b64e_queue.sv]
// ---------------------------------------------------------------------------
// base64 encoder group queue
// short first-in first-out store between the front and the back
// ---------------------------------------------------------------------------
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64e_pkg::group_type push_group,
   input  logic                pop,
   output b64e_pkg::group_type head_group,
   output logic                full,
   output logic                empty
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_group = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("group pushed into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

[sv/b64e_back.sv]
// ---------------------------------------------------------------------------
// base64 encoder back
// turns each queued group into four characters, one per cycle while rsp_ready is high
// ---------------------------------------------------------------------------
module b64e_back (
   input  logic                          clock,
   input  logic                          reset,
   input  b64e_pkg::group_type           head_group,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [b64e_pkg::BYTE_W-1:0]   out_char,
   output logic                          last_char
);
   import b64e_pkg::*;

   group_type           cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_char_ff, out_char_in;
   logic                out_last_ff, out_last_in;
   logic                out_free, step, cur_done;
   logic [SEXTET_W-1:0] sextet;
   logic [BYTE_W-1:0]   b0, b1, b2;

   assign b0 = cur_ff.bytes[BYTE_W-1:0];
   assign b1 = cur_ff.bytes[2*BYTE_W-1:BYTE_W];
   assign b2 = cur_ff.bytes[3*BYTE_W-1:2*BYTE_W];

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = b0[7:2];
         2'd1:    sextet = {b0[1:0], b1[7:4]};
         2'd2:    sextet = {b1[3:0], b2[7:6]};
         default: sextet = b2[5:0];
      endcase
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign step     = cur_valid_ff && out_free;
   assign cur_done = step && (idx_ff == 2'd3);
   assign pop      = !empty && (!cur_valid_ff || cur_done);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         idx_in       = idx_ff + 1'b1;
         out_valid_in = 1'b1;
         out_char_in  = ({1'b0, idx_ff} < cur_ff.keep) ? b64e_char(sextet) : PAD_CHAR;
         out_last_in  = cur_ff.last && (idx_ff == 2'd3);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cur_done) begin
         cur_valid_in = 1'b0;
      end
      if (pop) begin
         cur_in       = head_group;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign last_char = out_last_ff;

`ifndef SYNTHESIS
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> cur_valid_ff && (idx_ff == 2'd0)) else $error("group not loaded");
   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      cur_done |=> out_valid_ff) else $error("final character not presented");
`endif

endmodule

[sv/base64_encoder_top.sv]
// ---------------------------------------------------------------------------
// base64 encoder top level
// padded base64 encoding of byte messages, one character per result
// ---------------------------------------------------------------------------
// usage
//   req channel: one message byte per request in req_tdata, req_tlast high
//   on the last byte of the message
//   rsp channel: one character per transfer in rsp_tdata (alphabet or '='),
//   rsp_tlast high on the final character of the message
//   every third byte, and every last byte, yields four characters
//   a group that a byte closes is queued, then loaded into the back end's
//   current group register; its characters leave from the output register
//   throughput: one character per cycle on rsp while rsp_tready is high,
//   set by the character serialiser in the back end; req takes three bytes
//   per four characters; a small group queue lets req keep taking bytes
//   while rsp is stalled; req_tready drops only when the queue is full
//   reset clears the group position, the queue and the output register
// ---------------------------------------------------------------------------
module base64_encoder_top #(
   parameter int QUEUE_DEPTH = b64e_pkg::DEF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_char
   output logic       rsp_tlast
);
   import b64e_pkg::*;

   logic      push, pop, full, empty;
   group_type push_group, head_group;

   assign req_tready = !full;

   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .data_byte      (req_tdata),
      .end_of_message (req_tlast),
      .push           (push),
      .push_group     (push_group)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .full       (full),
      .empty      (empty)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_group (head_group),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .out_char   (rsp_tdata),
      .last_char  (rsp_tlast)
   );

endmodule

[tb/sv/base64_encoder_top_tb.sv]
// ---------------------------------------------------------------------------
// base64 encoder testbench
// drives byte messages into req and checks every character on rsp against
// a padded base64 prediction kept alongside; directed messages first, then
// random ones under random idling, then a stretch at full rate
// ---------------------------------------------------------------------------
module base64_encoder_top_tb;
   import b64e_pkg::*;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } b64_char_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] data_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic       rsp_tlast;

   string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   b64_char_type expected_chars[$];
   logic [1:0]  group_pos = 2'd0;
   logic [7:0]  held_bytes [2];
   int unsigned mismatches = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_stall_on = 1'b1;
   int unsigned stall_left = 0;

   base64_encoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] sextet_char(input logic [5:0] code);
      return alphabet[code];
   endfunction

   task automatic queue_group(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [2:0] keep,
                              input logic last);
      logic [23:0]  bits;
      b64_char_type c;
      bits = {b0, b1, b2};
      for (int k = 0; k < 4; k++) begin
         c.out_char  = (k < keep) ? sextet_char(bits[23-6*k -: 6]) : PAD_CHAR;
         c.last_char = last && (k == 3);
         expected_chars = {expected_chars, c};
      end
   endtask

   task automatic predict_byte(input logic [7:0] data, input logic eom);
      if (group_pos == 2'd2) begin
         queue_group(held_bytes[0], held_bytes[1], data, KEEP_FULL, eom);
         group_pos = 2'd0;
      end else if (eom) begin
         if (group_pos == 2'd0) begin
            queue_group(data, 8'h00, 8'h00, KEEP_ONE_BYTE, 1'b1);
         end else begin
            queue_group(held_bytes[0], data, 8'h00, KEEP_TWO_BYTES, 1'b1);
         end
         group_pos = 2'd0;
      end else begin
         held_bytes[group_pos[0]] = data;
         group_pos = group_pos + 2'd1;
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic eom);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      predict_byte(data, eom);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(8'($urandom), i == len - 1);
      end
   endtask

   // one byte left over: two characters and two pads
   task automatic test_one_byte_messages();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b1);
      wait_drained();
   endtask

   // two bytes left over: three characters and one pad
   task automatic test_two_byte_messages();
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b1);
      wait_drained();
   endtask

   // message ending on a full group, no padding
   task automatic test_full_group_end();
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      wait_drained();
   endtask

   task automatic test_multi_group_message();
      send_byte(8'h66, 1'b0);
      send_byte(8'h6F, 1'b0);
      send_byte(8'h6F, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h72, 1'b1);
      wait_drained();
   endtask

   // random lengths, mostly short, now and then a long one; before a byte,
   // also mid-message, the sender sometimes holds off until all characters are out
   task automatic test_random_messages(input int unsigned target);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < target) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 48) : $urandom_range(1, 9);
         for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 39) == 0) begin
               wait_drained();
            end
            send_byte(8'($urandom), i == len - 1);
         end
         sent += len;
      end
      wait_drained();
   endtask

   task automatic test_full_rate(input int unsigned target);
      int unsigned sent;
      int unsigned len;
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      sent = 0;
      while (sent < target) begin
         len = $urandom_range(1, 12);
         send_random_message(len);
         sent += len;
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      b64_char_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character: out_char %h, last_char %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last_char) begin
               $error("last_char: expected %b, got %b", want.last_char, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_one_byte_messages();
      test_two_byte_messages();
      test_full_group_end();
      test_multi_group_message();
      test_random_messages(270);
      test_full_rate(50);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
